/* src/spectral_partial_splatter_unit_macros.svh */
// Assertion macros for the spectral partial splatter unit.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SPECTRAL_PARTIAL_SPLATTER_UNIT_MACROS_SVH
`define SPECTRAL_PARTIAL_SPLATTER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SPSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spsu: implication check failed");
// Next-cycle implication.
`define SPSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spsu: next-cycle check failed");
`else
`define SPSU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SPSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/spsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsu_pkg
// Constants, types and the window spectrum table of the partial splatter.
// ----------------------------------------------------------------------------
package spsu_pkg;

   localparam int FFT_SIZE      = 512;
   localparam int TAPS_PER_SIDE = 8;
   localparam int OVERSAMPLE    = 16;

   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int DATA_W      = 32;

   localparam int TAPS      = 2 * TAPS_PER_SIDE;
   localparam int TAP_W     = $clog2(TAPS);
   localparam int CENTRE    = TAPS_PER_SIDE * OVERSAMPLE;
   localparam int ROM_LEN   = 2 * CENTRE + 1;
   localparam int HALF_LEN  = CENTRE + 1;
   localparam int HALF_W    = $clog2(HALF_LEN);
   localparam int ROM_IDX_W = $clog2(ROM_LEN);
   localparam int ROM_W     = 18;
   localparam int MOTIF_ON  = OVERSAMPLE * FFT_SIZE;
   localparam int MOTIF_SH  = $clog2(FFT_SIZE) + 13;

   localparam int BIN_LIMIT   = (FFT_SIZE / 2 < STORE_DEPTH) ? FFT_SIZE / 2 : STORE_DEPTH;
   localparam int REJECT_LOW  = 256;
   localparam int REJECT_HIGH = (FFT_SIZE / 2 - 1) * 256;

   localparam int K_W    = $clog2(STORE_DEPTH + TAPS) + 1;
   localparam int X_W    = $clog2(TAPS * 256 * OVERSAMPLE + 1);
   localparam int FRAC_W = 9;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int W_W    = 28;
   localparam int Q_W    = 36;
   localparam int D_W    = 40;

   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned PA1 = 64'd1686629713;
   localparam longint unsigned PA3 = 64'd693598668;
   localparam longint unsigned PA5 = 64'd85569306;
   localparam longint unsigned PA7 = 64'd5027003;
   localparam longint unsigned PA9 = 64'd172273;

   typedef enum logic {
      CMD_PLACE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_PLACED   = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_READ     = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      SPSU_IDLE,
      SPSU_RD_DATA,
      SPSU_SC_X2,
      SPSU_SC_P9,
      SPSU_SC_P7,
      SPSU_SC_P5,
      SPSU_SC_P3,
      SPSU_SC_P1,
      SPSU_SC_S,
      SPSU_SC_C,
      SPSU_TP_ADDR,
      SPSU_TP_W0,
      SPSU_TP_W1,
      SPSU_TP_W2,
      SPSU_TP_MR,
      SPSU_TP_MI,
      SPSU_TP_Q,
      SPSU_TP_WR,
      SPSU_FINISH
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } bin_rd_type;

   typedef struct packed {
      logic                     en;
      logic [ADDR_W-1:0]        addr;
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
   } bin_wr_type;

   typedef logic [HALF_LEN-1:0][ROM_W-1:0] motif_half_type;

   // Quarter-wave sine in Q30, evaluated at elaboration only.
   function automatic longint sin_const(input logic [31:0] ph);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      logic [1:0]      quad;
      quad = ph[31:30];
      x    = {34'd0, ph[29:0]};
      if (quad[0]) begin
         x = (64'd1 << 30) - x;
      end
      x2 = (x * x) >> 30;
      t  = PA7 - ((x2 * PA9) >> 30);
      t  = PA5 - ((x2 * t) >> 30);
      t  = PA3 - ((x2 * t) >> 30);
      t  = PA1 - ((x2 * t) >> 30);
      s  = (x * t) >> 30;
      if (s > (64'd1 << 30)) begin
         s = 64'd1 << 30;
      end
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint cos_const(input logic [31:0] ph);
      return sin_const(ph + 32'h4000_0000);
   endfunction

   // One half of the symmetric window spectrum, indexed by distance from the centre.
   function automatic motif_half_type build_motif();
      motif_half_type  r;
      longint          acc;
      longint          c;
      longint unsigned am;
      longint unsigned wph;
      longint unsigned v;
      longint unsigned u;
      longint unsigned cm;
      longint unsigned p;
      longint unsigned mag;
      r  = '0;
      for (int i = 0; i < HALF_LEN; i++) begin
         acc = 0;
         for (int m = -(FFT_SIZE / 2); m < FFT_SIZE - FFT_SIZE / 2; m++) begin
            am  = (m < 0) ? longint'(-m) : longint'(m);
            wph = ((am % FFT_SIZE) << 32) / FFT_SIZE;
            v   = longint'(Q30_ONE + cos_const(wph[31:0])) >> 1;
            u   = (longint'(i) * am) % MOTIF_ON;
            wph = (u << 32) / MOTIF_ON;
            c   = cos_const(wph[31:0]);
            cm  = (c < 0) ? longint'(-c) : longint'(c);
            p   = (v * cm) >> 30;
            acc = (c < 0) ? acc - longint'(p) : acc + longint'(p);
         end
         mag = (acc < 0) ? longint'(-acc) : longint'(acc);
         mag = (mag + (64'd1 << (MOTIF_SH - 1))) >> MOTIF_SH;
         if (mag > 64'd131071) begin
            mag = 64'd131071;
         end
         r[i] = (acc < 0) ? -mag[ROM_W-1:0] : mag[ROM_W-1:0];
      end
      return r;
   endfunction

   localparam motif_half_type MOTIF_HALF = build_motif();

endpackage

/* src/spsu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsu_if
// Request and response channels of the partial splatter (valid/ready).
// ----------------------------------------------------------------------------
interface spsu_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [15:0]        bin_pos;
   logic signed [15:0] amplitude;
   logic [15:0]        phase_turns;
   logic [7:0]         read_index;

   modport source (output valid, cmd, bin_pos, amplitude, phase_turns, read_index,
                   input ready);
   modport sink   (input valid, cmd, bin_pos, amplitude, phase_turns, read_index,
                   output ready);
endinterface

interface spsu_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] re_value;
   logic signed [31:0] im_value;

   modport source (output valid, status, re_value, im_value, input ready);
   modport sink   (input valid, status, re_value, im_value, output ready);
endinterface

/* src/spsu_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module spsu_mul (
   input  logic                                  clock,
   input  logic signed [spsu_pkg::MUL_W-1:0]     a,
   input  logic signed [spsu_pkg::MUL_W-1:0]     b,
   output logic signed [spsu_pkg::PROD_W-1:0]    p
);
   logic signed [spsu_pkg::PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= spsu_pkg::PROD_W'(a) * spsu_pkg::PROD_W'(b);
   end

   assign p = p_ff;
endmodule

/* src/spsu_bins.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsu_bins
// Real and imaginary bin accumulators; unwritten bins read as zero.
// ----------------------------------------------------------------------------
module spsu_bins (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spsu_pkg::bin_rd_type                 rd,
   input  spsu_pkg::bin_wr_type                 wr,
   output logic signed [spsu_pkg::DATA_W-1:0]   rd_re,
   output logic signed [spsu_pkg::DATA_W-1:0]   rd_im
);
   logic signed [spsu_pkg::DATA_W-1:0] re_mem [spsu_pkg::STORE_DEPTH];
   logic signed [spsu_pkg::DATA_W-1:0] im_mem [spsu_pkg::STORE_DEPTH];
   logic [spsu_pkg::STORE_DEPTH-1:0]   valid_ff;
   logic signed [spsu_pkg::DATA_W-1:0] rd_re_ff;
   logic signed [spsu_pkg::DATA_W-1:0] rd_im_ff;

   // A bin counts as zero until its first write after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         re_mem[wr.addr] <= wr.re;
         im_mem[wr.addr] <= wr.im;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_re_ff <= valid_ff[rd.addr] ? re_mem[rd.addr] : '0;
         rd_im_ff <= valid_ff[rd.addr] ? im_mem[rd.addr] : '0;
      end
   end

   assign rd_re = rd_re_ff;
   assign rd_im = rd_im_ff;
endmodule

/* src/spectral_partial_splatter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_partial_splatter_unit
// Places windowed partials into a packed half-spectrum and reads bins back, clearing each bin read.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// req_ch    in         cmd, bin_pos, amplitude, phase_turns, read_index
// rsp_ch    out        status, re_value, im_value (one beat per request)
//
// A read request passes through the read step and the final step. A placed
// partial runs the cosine and then the sine (eight steps each, seven of them
// through the shared multiplier), then per tap inside the bin store the address,
// two weight products, their sum, real and imaginary products, scaling and
// write-back steps, or just the address step per skipped tap, between an accept
// step and a final hand-over step. The request side is ready only while the
// sequencer is idle. A rejected partial goes from accept straight to hand-over.
// Reset clears the bin store at once through per-bin valid bits.
// A stalled response sits in the output register while the next request is
// already accepted; the sequencer waits at its final step for the slot.
//
`include "spectral_partial_splatter_unit_macros.svh"

module spectral_partial_splatter_unit (
   input logic        clock,
   input logic        reset,
   spsu_req_if.sink   req_ch,
   spsu_rsp_if.source rsp_ch
);

   // Half-away-from-zero rounding right shift of a product-wide value.
   function automatic logic signed [spsu_pkg::PROD_W-1:0] round_shift(
      input logic signed [spsu_pkg::PROD_W-1:0] v,
      input int                                 sh
   );
      logic signed [spsu_pkg::PROD_W-1:0] mag;
      logic signed [spsu_pkg::PROD_W-1:0] r;
      mag = (v < 0) ? -v : v;
      r   = (mag + (spsu_pkg::PROD_W'(1) << (sh - 1))) >> sh;
      return (v < 0) ? -r : r;
   endfunction

   // Scale by the FFT size over 2^10 with rounding, negate on odd bins.
   function automatic logic signed [spsu_pkg::D_W-1:0] scale_tap(
      input logic signed [spsu_pkg::Q_W-1:0] q,
      input logic                            odd
   );
      logic signed [spsu_pkg::PROD_W-1:0] v;
      logic signed [spsu_pkg::PROD_W-1:0] r;
      v = spsu_pkg::PROD_W'(q) * $signed(spsu_pkg::PROD_W'(spsu_pkg::FFT_SIZE));
      r = round_shift(v, 10);
      if (odd) begin
         r = -r;
      end
      return r[spsu_pkg::D_W-1:0];
   endfunction

   function automatic logic signed [spsu_pkg::DATA_W-1:0] sat_add(
      input logic signed [spsu_pkg::DATA_W-1:0] a,
      input logic signed [spsu_pkg::D_W-1:0]    b
   );
      logic signed [spsu_pkg::D_W:0] s;
      s = (spsu_pkg::D_W+1)'(a) + (spsu_pkg::D_W+1)'(b);
      if (s > (spsu_pkg::D_W+1)'(32'sh7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end else if (s < (spsu_pkg::D_W+1)'(32'sh8000_0000)) begin
         return 32'sh8000_0000;
      end
      return s[spsu_pkg::DATA_W-1:0];
   endfunction

   // The window table is symmetric, so only one half is kept.
   function automatic logic signed [spsu_pkg::ROM_W-1:0] motif_at(
      input logic [spsu_pkg::ROM_IDX_W-1:0] i
   );
      logic [spsu_pkg::ROM_IDX_W-1:0] a;
      a = (i >= spsu_pkg::ROM_IDX_W'(spsu_pkg::CENTRE))
          ? i - spsu_pkg::ROM_IDX_W'(spsu_pkg::CENTRE)
          : spsu_pkg::ROM_IDX_W'(spsu_pkg::CENTRE) - i;
      return $signed(spsu_pkg::MOTIF_HALF[a[spsu_pkg::HALF_W-1:0]]);
   endfunction

   // Reduced angle for the polynomial: cosine runs as sine a quarter turn on.
   function automatic logic [31:0] angle_word(input logic [15:0] phase, input logic is_sin);
      return {phase, 16'd0} + (is_sin ? 32'd0 : 32'h4000_0000);
   endfunction

   spsu_pkg::state_type state_ff, state_in;

   logic [15:0]                          binpos_ff, binpos_in;
   logic [15:0]                          phase_ff, phase_in;
   logic signed [15:0]                   amp_ff, amp_in;
   logic                                 angle_ff, angle_in;
   logic [30:0]                          x_ff, x_in;
   logic                                 neg_ff, neg_in;
   logic [30:0]                          x2_ff, x2_in;
   logic signed [31:0]                   cr_ff, cr_in;
   logic signed [31:0]                   ci_ff, ci_in;
   logic [spsu_pkg::TAP_W-1:0]           tap_ff, tap_in;
   logic [spsu_pkg::ADDR_W-1:0]          k_ff, k_in;
   logic [spsu_pkg::ROM_IDX_W-1:0]       i0_ff, i0_in;
   logic [spsu_pkg::FRAC_W-1:0]          f_ff, f_in;
   logic signed [spsu_pkg::W_W-1:0]      w_ff, w_in;
   logic signed [spsu_pkg::Q_W-1:0]      qr_ff, qr_in;
   logic signed [spsu_pkg::Q_W-1:0]      qi_ff, qi_in;
   logic signed [spsu_pkg::D_W-1:0]      dr_ff, dr_in;
   logic [1:0]                           res_status_ff, res_status_in;
   logic signed [31:0]                   res_re_ff, res_re_in;
   logic signed [31:0]                   res_im_ff, res_im_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]                           rsp_status_ff, rsp_status_in;
   logic signed [31:0]                   rsp_re_ff, rsp_re_in;
   logic signed [31:0]                   rsp_im_ff, rsp_im_in;

   logic signed [spsu_pkg::MUL_W-1:0]    mul_a;
   logic signed [spsu_pkg::MUL_W-1:0]    mul_b;
   logic signed [spsu_pkg::PROD_W-1:0]   mul_p;
   logic [spsu_pkg::PROD_W-1:0]          p_hi;
   logic signed [spsu_pkg::PROD_W-1:0]   p_rnd;
   logic signed [spsu_pkg::PROD_W-1:0]   p_rnd15;

   spsu_pkg::bin_rd_type                 bin_rd;
   spsu_pkg::bin_wr_type                 bin_wr;
   logic signed [spsu_pkg::DATA_W-1:0]   bin_re;
   logic signed [spsu_pkg::DATA_W-1:0]   bin_im;

   logic                                 req_fire;
   logic                                 rsp_free;
   logic                                 reject;
   logic                                 last_tap;
   logic [31:0]                          ang;
   logic [30:0]                          ang_x;
   logic [31:0]                          s_raw;
   logic signed [31:0]                   s_val;

   logic signed [spsu_pkg::K_W-1:0]      k_calc;
   logic                                 tap_skip;
   logic [spsu_pkg::X_W-1:0]             d_calc;
   logic [spsu_pkg::X_W-1:0]             x_calc;
   logic [spsu_pkg::X_W-1:0]             i0_raw;
   logic [spsu_pkg::ROM_IDX_W-1:0]       i0_calc;
   logic [spsu_pkg::X_W-1:0]             f_raw;

   spsu_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   spsu_bins u_bins (
      .clock (clock),
      .reset (reset),
      .rd    (bin_rd),
      .wr    (bin_wr),
      .rd_re (bin_re),
      .rd_im (bin_im)
   );

   assign req_ch.ready    = (state_ff == spsu_pkg::SPSU_IDLE) && !reset;
   assign req_fire        = req_ch.valid && req_ch.ready;
   assign rsp_free        = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.re_value = rsp_re_ff;
   assign rsp_ch.im_value = rsp_im_ff;

   assign reject = (32'(req_ch.bin_pos) <= 32'(spsu_pkg::REJECT_LOW)) ||
                   (32'(req_ch.bin_pos) >= 32'(spsu_pkg::REJECT_HIGH));

   // Product shifts: truncated by 30 bits for the polynomial steps, rounded by 30 or 15 bits for the others.
   assign p_hi    = mul_p >> 30;
   assign p_rnd   = round_shift(mul_p, 30);
   assign p_rnd15 = round_shift(mul_p, 15);
   assign s_raw   = p_hi[31:0];
   assign s_val   = (s_raw > 32'h4000_0000)
                    ? (neg_ff ? -32'sh4000_0000 : 32'sh4000_0000)
                    : (neg_ff ? -$signed(s_raw) : $signed(s_raw));

   // Tap geometry: bin index, table position and interpolation fraction.
   assign k_calc   = spsu_pkg::K_W'({1'b0, binpos_ff[15:8]}) + spsu_pkg::K_W'(tap_ff)
                     - spsu_pkg::K_W'(spsu_pkg::TAPS_PER_SIDE - 1);
   assign tap_skip = (k_calc <= 0) || (k_calc >= spsu_pkg::BIN_LIMIT);
   assign d_calc   = ((spsu_pkg::X_W'(tap_ff) + spsu_pkg::X_W'(1)) << 8)
                     - spsu_pkg::X_W'(binpos_ff[7:0]);
   assign x_calc   = spsu_pkg::X_W'(d_calc * spsu_pkg::X_W'(spsu_pkg::OVERSAMPLE));
   assign i0_raw   = x_calc >> 8;
   assign i0_calc  = (i0_raw > spsu_pkg::X_W'(spsu_pkg::ROM_LEN - 2))
                     ? spsu_pkg::ROM_IDX_W'(spsu_pkg::ROM_LEN - 2)
                     : i0_raw[spsu_pkg::ROM_IDX_W-1:0];
   assign f_raw    = x_calc - (spsu_pkg::X_W'(i0_calc) << 8);
   assign last_tap = (tap_ff == spsu_pkg::TAP_W'(spsu_pkg::TAPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spsu_pkg::SPSU_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      binpos_ff     <= binpos_in;
      phase_ff      <= phase_in;
      amp_ff        <= amp_in;
      angle_ff      <= angle_in;
      x_ff          <= x_in;
      neg_ff        <= neg_in;
      x2_ff         <= x2_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      tap_ff        <= tap_in;
      k_ff          <= k_in;
      i0_ff         <= i0_in;
      f_ff          <= f_in;
      w_ff          <= w_in;
      qr_ff         <= qr_in;
      qi_ff         <= qi_in;
      dr_ff         <= dr_in;
      res_status_ff <= res_status_in;
      res_re_ff     <= res_re_in;
      res_im_ff     <= res_im_in;
      rsp_status_ff <= rsp_status_in;
      rsp_re_ff     <= rsp_re_in;
      rsp_im_ff     <= rsp_im_in;
   end

   always_comb begin
      state_in      = state_ff;
      binpos_in     = binpos_ff;
      phase_in      = phase_ff;
      amp_in        = amp_ff;
      angle_in      = angle_ff;
      x_in          = x_ff;
      neg_in        = neg_ff;
      x2_in         = x2_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      tap_in        = tap_ff;
      k_in          = k_ff;
      i0_in         = i0_ff;
      f_in          = f_ff;
      w_in          = w_ff;
      qr_in         = qr_ff;
      qi_in         = qi_ff;
      dr_in         = dr_ff;
      res_status_in = res_status_ff;
      res_re_in     = res_re_ff;
      res_im_in     = res_im_ff;
      rsp_status_in = rsp_status_ff;
      rsp_re_in     = rsp_re_ff;
      rsp_im_in     = rsp_im_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mul_a         = '0;
      mul_b         = '0;
      bin_rd        = '0;
      bin_wr        = '0;
      ang           = angle_word(phase_ff, angle_ff);
      ang_x         = '0;

      case (state_ff)
         spsu_pkg::SPSU_IDLE: begin
            if (req_fire) begin
               binpos_in = req_ch.bin_pos;
               phase_in  = req_ch.phase_turns;
               amp_in    = req_ch.amplitude;
               res_re_in = '0;
               res_im_in = '0;
               if (req_ch.cmd == spsu_pkg::CMD_READ) begin
                  bin_rd.en   = 1'b1;
                  bin_rd.addr = req_ch.read_index;
                  k_in        = req_ch.read_index;
                  state_in    = spsu_pkg::SPSU_RD_DATA;
               end else if (reject) begin
                  res_status_in = spsu_pkg::STATUS_REJECTED;
                  state_in      = spsu_pkg::SPSU_FINISH;
               end else begin
                  // Cosine first, for the real part.
                  ang      = angle_word(req_ch.phase_turns, 1'b0);
                  ang_x    = {1'b0, ang[29:0]};
                  x_in     = ang[30] ? (31'h4000_0000 - ang_x) : ang_x;
                  neg_in   = ang[31];
                  angle_in = 1'b0;
                  state_in = spsu_pkg::SPSU_SC_X2;
               end
            end
         end
         spsu_pkg::SPSU_RD_DATA: begin
            res_status_in = spsu_pkg::STATUS_READ;
            res_re_in     = bin_re;
            res_im_in     = bin_im;
            bin_wr.en     = 1'b1;
            bin_wr.addr   = k_ff;
            state_in      = spsu_pkg::SPSU_FINISH;
         end
         spsu_pkg::SPSU_SC_X2: begin
            mul_a    = spsu_pkg::MUL_W'(x_ff);
            mul_b    = spsu_pkg::MUL_W'(x_ff);
            state_in = spsu_pkg::SPSU_SC_P9;
         end
         spsu_pkg::SPSU_SC_P9: begin
            x2_in    = p_hi[30:0];
            mul_a    = spsu_pkg::MUL_W'(p_hi[30:0]);
            mul_b    = spsu_pkg::MUL_W'(spsu_pkg::PA9[31:0]);
            state_in = spsu_pkg::SPSU_SC_P7;
         end
         spsu_pkg::SPSU_SC_P7: begin
            mul_a    = spsu_pkg::MUL_W'(x2_ff);
            mul_b    = spsu_pkg::MUL_W'(spsu_pkg::PA7[31:0] - p_hi[31:0]);
            state_in = spsu_pkg::SPSU_SC_P5;
         end
         spsu_pkg::SPSU_SC_P5: begin
            mul_a    = spsu_pkg::MUL_W'(x2_ff);
            mul_b    = spsu_pkg::MUL_W'(spsu_pkg::PA5[31:0] - p_hi[31:0]);
            state_in = spsu_pkg::SPSU_SC_P3;
         end
         spsu_pkg::SPSU_SC_P3: begin
            mul_a    = spsu_pkg::MUL_W'(x2_ff);
            mul_b    = spsu_pkg::MUL_W'(spsu_pkg::PA3[31:0] - p_hi[31:0]);
            state_in = spsu_pkg::SPSU_SC_P1;
         end
         spsu_pkg::SPSU_SC_P1: begin
            mul_a    = spsu_pkg::MUL_W'(x_ff);
            mul_b    = spsu_pkg::MUL_W'(spsu_pkg::PA1[31:0] - p_hi[31:0]);
            state_in = spsu_pkg::SPSU_SC_S;
         end
         spsu_pkg::SPSU_SC_S: begin
            mul_a    = spsu_pkg::MUL_W'(amp_ff);
            mul_b    = spsu_pkg::MUL_W'(s_val);
            state_in = spsu_pkg::SPSU_SC_C;
         end
         spsu_pkg::SPSU_SC_C: begin
            if (!angle_ff) begin
               cr_in    = p_rnd15[31:0];
               ang      = angle_word(phase_ff, 1'b1);
               ang_x    = {1'b0, ang[29:0]};
               x_in     = ang[30] ? (31'h4000_0000 - ang_x) : ang_x;
               neg_in   = ang[31];
               angle_in = 1'b1;
               state_in = spsu_pkg::SPSU_SC_X2;
            end else begin
               ci_in    = p_rnd15[31:0];
               tap_in   = '0;
               state_in = spsu_pkg::SPSU_TP_ADDR;
            end
         end
         spsu_pkg::SPSU_TP_ADDR: begin
            k_in  = k_calc[spsu_pkg::ADDR_W-1:0];
            i0_in = i0_calc;
            f_in  = (f_raw > spsu_pkg::X_W'(256)) ? spsu_pkg::FRAC_W'(256)
                                                 : f_raw[spsu_pkg::FRAC_W-1:0];
            if (tap_skip) begin
               // Taps on or below DC, on Nyquist or past the store do nothing.
               if (last_tap) begin
                  res_status_in = spsu_pkg::STATUS_PLACED;
                  state_in      = spsu_pkg::SPSU_FINISH;
               end else begin
                  tap_in = tap_ff + 1'b1;
               end
            end else begin
               bin_rd.en   = 1'b1;
               bin_rd.addr = k_calc[spsu_pkg::ADDR_W-1:0];
               state_in    = spsu_pkg::SPSU_TP_W0;
            end
         end
         spsu_pkg::SPSU_TP_W0: begin
            mul_a    = spsu_pkg::MUL_W'(motif_at(i0_ff));
            mul_b    = spsu_pkg::MUL_W'(spsu_pkg::FRAC_W'(256) - f_ff);
            state_in = spsu_pkg::SPSU_TP_W1;
         end
         spsu_pkg::SPSU_TP_W1: begin
            w_in     = mul_p[spsu_pkg::W_W-1:0];
            mul_a    = spsu_pkg::MUL_W'(motif_at(i0_ff + 1'b1));
            mul_b    = spsu_pkg::MUL_W'(f_ff);
            state_in = spsu_pkg::SPSU_TP_W2;
         end
         spsu_pkg::SPSU_TP_W2: begin
            w_in     = w_ff + mul_p[spsu_pkg::W_W-1:0];
            state_in = spsu_pkg::SPSU_TP_MR;
         end
         spsu_pkg::SPSU_TP_MR: begin
            mul_a    = spsu_pkg::MUL_W'(w_ff);
            mul_b    = spsu_pkg::MUL_W'(cr_ff);
            state_in = spsu_pkg::SPSU_TP_MI;
         end
         spsu_pkg::SPSU_TP_MI: begin
            qr_in    = p_rnd[spsu_pkg::Q_W-1:0];
            mul_a    = spsu_pkg::MUL_W'(w_ff);
            mul_b    = spsu_pkg::MUL_W'(ci_ff);
            state_in = spsu_pkg::SPSU_TP_Q;
         end
         spsu_pkg::SPSU_TP_Q: begin
            qi_in    = p_rnd[spsu_pkg::Q_W-1:0];
            dr_in    = scale_tap(qr_ff, k_ff[0]);
            state_in = spsu_pkg::SPSU_TP_WR;
         end
         spsu_pkg::SPSU_TP_WR: begin
            bin_wr.en   = 1'b1;
            bin_wr.addr = k_ff;
            bin_wr.re   = sat_add(bin_re, dr_ff);
            bin_wr.im   = sat_add(bin_im, scale_tap(qi_ff, k_ff[0]));
            if (last_tap) begin
               res_status_in = spsu_pkg::STATUS_PLACED;
               state_in      = spsu_pkg::SPSU_FINISH;
            end else begin
               tap_in   = tap_ff + 1'b1;
               state_in = spsu_pkg::SPSU_TP_ADDR;
            end
         end
         spsu_pkg::SPSU_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_re_in     = res_re_ff;
               rsp_im_in     = res_im_ff;
               state_in      = spsu_pkg::SPSU_IDLE;
            end
         end
         default: begin
            state_in = spsu_pkg::SPSU_IDLE;
         end
      endcase
   end

   // Placed and rejected beats carry zero data values.
   `SPSU_ASSERT_IMPLY(a_status_data, clock, reset, rsp_ch.valid && (rsp_ch.status != spsu_pkg::STATUS_READ), (rsp_ch.re_value == 32'sd0) && (rsp_ch.im_value == 32'sd0))
   // Accepting a request always starts the sequencer.
   `SPSU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, state_ff != spsu_pkg::SPSU_IDLE)
   // Tap updates never land on the DC bin.
   `SPSU_ASSERT_IMPLY(a_no_dc_write, clock, reset, bin_wr.en && (state_ff == spsu_pkg::SPSU_TP_WR), bin_wr.addr != '0)

endmodule
